// File: src/dtwp_pkg.sv
`default_nettype none

package dtwp_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int DISP_FRAC_BITS_DEF = 4;
    localparam int DISP_W             = 12;
    localparam int MIN_DISP_PX        = 5;
    localparam int ROT_FRAC           = 14;
    localparam int ROT_W              = 16;
    localparam int TRANS_W            = 21;
    localparam int Z_BITS             = 30;
    localparam int OUT_W              = 32;
    localparam int CFG_IDX_W          = 4;
    localparam int CFG_DATA_W         = 64;
    localparam int Q_DEPTH            = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_SCALE = 4'd0,
        REG_FOCAL_X     = 4'd1,
        REG_FOCAL_Y     = 4'd2,
        REG_PRINCIPAL   = 4'd3,
        REG_ROT_ROW0    = 4'd4,
        REG_ROT_ROW1    = 4'd5,
        REG_ROT_ROW2    = 4'd6,
        REG_TRANSLATION = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]                     depth_scale;
        logic [15:0]                     focal_x;
        logic [15:0]                     focal_y;
        logic [15:0]                     cx;
        logic [15:0]                     cy;
        logic [2:0][2:0][ROT_W-1:0]      rot;
        logic [2:0][TRANS_W-1:0]         trans;
    } cfg_t;

endpackage

`default_nettype wire

// File: src/dtwp_div_pipe.sv
`default_nettype none

module dtwp_div_pipe
    import dtwp_pkg::*;
#(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 12,
    parameter int SIDE_W = 1
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quot,
    output logic [SIDE_W-1:0]      out_side
);

    // one quotient bit per stage, restoring
    logic              v_reg    [NUM_W+1];
    logic [DEN_W-1:0]  rem_reg  [NUM_W+1];
    logic [NUM_W-1:0]  quot_reg [NUM_W+1];
    logic [NUM_W-1:0]  num_reg  [NUM_W+1];
    logic [DEN_W-1:0]  den_reg  [NUM_W+1];
    logic [SIDE_W-1:0] side_reg [NUM_W+1];

    assign v_reg[0]    = in_valid;
    assign rem_reg[0]  = '0;
    assign quot_reg[0] = '0;
    assign num_reg[0]  = in_num;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++) begin : g_stage
            logic [DEN_W:0]   trial;
            logic             qbit;
            logic [DEN_W:0]   diff;
            assign trial = {rem_reg[i], num_reg[i][NUM_W-1]};
            assign qbit  = (trial >= {1'b0, den_reg[i]});
            assign diff  = trial - {1'b0, den_reg[i]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else
                begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i+1]  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quot_reg[i+1] <= {quot_reg[i][NUM_W-2:0], qbit};
                num_reg[i+1]  <= num_reg[i] << 1;
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    endgenerate

    assign out_valid = v_reg[NUM_W];
    assign out_quot  = quot_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

`default_nettype wire

// File: src/dtwp_queue.sv
`default_nettype none

module dtwp_queue
    import dtwp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty,
    output logic                  almost_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign empty       = (cnt_reg == '0);
    assign almost_full = (cnt_reg >= CNT_W'(DEPTH - 1));
    assign pop_data    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(DEPTH)) |-> !push || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: src/dtwp_front.sv
`default_nettype none

module dtwp_front
    import dtwp_pkg::*;
#(
    parameter int COORD_BITS              = COORD_BITS_DEF,
    parameter int DISPARITY_FRACTION_BITS = DISP_FRAC_BITS_DEF,
    parameter int DW = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  take,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    input  wire logic [DISP_W-1:0]     disparity,
    input  wire cfg_t                  cfg,
    output logic                       push,
    output logic [2*DW+DISP_W-1:0]     push_data
);

    localparam logic [DISP_W-1:0] DISP_MIN = DISP_W'(MIN_DISP_PX << DISPARITY_FRACTION_BITS);

    logic              v_reg;
    logic [DW-1:0]     dx_reg, dy_reg;
    logic [DISP_W-1:0] disp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= take && (disparity > DISP_MIN);
        end
    end

    // offsets from the principal point, two's complement
    always_ff @(posedge clk)
    begin
        dx_reg   <= DW'({column, 4'b0000}) - DW'(cfg.cx);
        dy_reg   <= DW'({row, 4'b0000}) - DW'(cfg.cy);
        disp_reg <= disparity;
    end

    assign push      = v_reg;
    assign push_data = {dx_reg, dy_reg, disp_reg};

endmodule

`default_nettype wire

// File: src/dtwp_back.sv
`default_nettype none

module dtwp_back
    import dtwp_pkg::*;
#(
    parameter int COORD_BITS              = COORD_BITS_DEF,
    parameter int DISPARITY_FRACTION_BITS = DISP_FRAC_BITS_DEF,
    parameter int DW = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [2*DW+DISP_W-1:0] in_data,
    input  wire cfg_t                  cfg,
    output logic                       done,
    output logic signed [OUT_W-1:0]    world_x,
    output logic signed [OUT_W-1:0]    world_y,
    output logic signed [OUT_W-1:0]    world_z
);

    localparam int NUM_W = 32 + DISPARITY_FRACTION_BITS;
    localparam int PMW   = DW + Z_BITS;
    localparam int CW    = PMW + 1;
    localparam int PRW   = CW + ROT_W;
    localparam int SW    = PRW + 2;

    // depth divider
    logic              zd_valid;
    logic [NUM_W-1:0]  zd_quot;
    logic [2*DW-1:0]   zd_side;

    dtwp_div_pipe #(.NUM_W(NUM_W), .DEN_W(DISP_W), .SIDE_W(2*DW)) u_zdiv (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid),
        .in_num(NUM_W'(cfg.depth_scale) << DISPARITY_FRACTION_BITS),
        .in_den(in_data[DISP_W-1:0]),
        .in_side(in_data[2*DW+DISP_W-1:DISP_W]),
        .out_valid(zd_valid), .out_quot(zd_quot), .out_side(zd_side)
    );

    // offset times depth
    logic                 m_v_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic [Z_BITS-1:0]    z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else
        begin
            m_v_reg <= zd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg  <= zd_quot[Z_BITS-1:0];
        px_reg <= $signed(zd_side[2*DW-1:DW]) * $signed({1'b0, zd_quot[Z_BITS-1:0]});
        py_reg <= $signed(zd_side[DW-1:0]) * $signed({1'b0, zd_quot[Z_BITS-1:0]});
    end

    logic [PMW-1:0] mag_x, mag_y;
    logic [CW-1:0]  neg_x, neg_y;
    logic [15:0]    fx, fy;

    assign neg_x = -px_reg;
    assign neg_y = -py_reg;
    assign mag_x = px_reg[CW-1] ? neg_x[PMW-1:0] : px_reg[PMW-1:0];
    assign mag_y = py_reg[CW-1] ? neg_y[PMW-1:0] : py_reg[PMW-1:0];
    assign fx    = (cfg.focal_x == '0) ? 16'd1 : cfg.focal_x;
    assign fy    = (cfg.focal_y == '0) ? 16'd1 : cfg.focal_y;

    logic              xd_valid, yd_valid;
    logic [PMW-1:0]    xd_quot, yd_quot;
    logic [Z_BITS:0]   xd_side;
    logic              yd_side;

    dtwp_div_pipe #(.NUM_W(PMW), .DEN_W(16), .SIDE_W(Z_BITS+1)) u_xdiv (
        .clk(clk), .rst_n(rst_n),
        .in_valid(m_v_reg), .in_num(mag_x), .in_den(fx),
        .in_side({px_reg[CW-1], z_reg}),
        .out_valid(xd_valid), .out_quot(xd_quot), .out_side(xd_side)
    );

    dtwp_div_pipe #(.NUM_W(PMW), .DEN_W(16), .SIDE_W(1)) u_ydiv (
        .clk(clk), .rst_n(rst_n),
        .in_valid(m_v_reg), .in_num(mag_y), .in_den(fy),
        .in_side(py_reg[CW-1]),
        .out_valid(yd_valid), .out_quot(yd_quot), .out_side(yd_side)
    );

    // camera point
    logic                 c_v_reg;
    logic signed [CW-1:0] cam_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else
        begin
            c_v_reg <= xd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cam_reg[0] <= xd_side[Z_BITS] ? -$signed({1'b0, xd_quot}) : $signed({1'b0, xd_quot});
        cam_reg[1] <= yd_side ? -$signed({1'b0, yd_quot}) : $signed({1'b0, yd_quot});
        cam_reg[2] <= $signed(CW'(xd_side[Z_BITS-1:0]));
    end

    // rotation products
    logic                  p_v_reg;
    logic signed [PRW-1:0] prod_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= c_v_reg;
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < 3; r++) begin : g_row
            for (c = 0; c < 3; c++) begin : g_col
                always_ff @(posedge clk)
                begin
                    prod_reg[r][c] <= $signed(cfg.rot[r][c]) * cam_reg[c];
                end
            end
        end
    endgenerate

    // sum, floor scale, translate, saturate
    logic                    o_v_reg;
    logic signed [OUT_W-1:0] w_reg [3];
    logic signed [SW-1:0]    sum   [3];
    logic signed [SW-1:0]    moved [3];
    logic signed [OUT_W-1:0] sat   [3];

    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k]   = SW'(prod_reg[k][0]) + SW'(prod_reg[k][1]) + SW'(prod_reg[k][2]);
            moved[k] = (sum[k] >>> ROT_FRAC) + SW'($signed(cfg.trans[k]));
            if (moved[k] > SAT_MAX)
            begin
                sat[k] = 32'sh7FFFFFFF;
            end
            else if (moved[k] < SAT_MIN)
            begin
                sat[k] = 32'sh80000000;
            end
            else
            begin
                sat[k] = moved[k][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg[0] <= sat[0];
        w_reg[1] <= sat[1];
        w_reg[2] <= sat[2];
    end

    assign done    = o_v_reg;
    assign world_x = w_reg[0];
    assign world_y = w_reg[1];
    assign world_z = w_reg[2];

    a_xy_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        xd_valid == yd_valid)
        else $error("x and y dividers out of step");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(c_v_reg, 2))
        else $error("result without camera point");
    a_mult_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_v_reg |-> $past(zd_valid))
        else $error("product without depth");

endmodule

`default_nettype wire

// File: src/disparity_to_world_point.sv
// Stereo disparity to world point.
// Input: start with column, row and disparity (Q.DISPARITY_FRACTION_BITS);
// the item transfers at a clock edge with start high and busy low. Pixels
// with disparity of 5 pixels or less produce no result.
// Output: done pulses for one cycle with world_x/y/z (signed mm, saturated).
// The receiver cannot stall; every result is taken on its done cycle.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, indexes above 7 are ignored. Write only while idle.
// Throughput: one pixel per clock. busy rises only if the queue between the
// classifying front and the arithmetic back nears full, which does not
// happen since the back drains one item every cycle.
// From transfer to done, an item passes the front register, the queue, the
// bit-per-stage depth divider, the offset multiply, the bit-per-stage x/y
// dividers by focal length, and the camera, rotation and output registers.
// Reset clears all valid state and loads identity rotation, unit focal
// lengths and zero scale, principal point and translation.
`default_nettype none

module disparity_to_world_point
    import dtwp_pkg::*;
#(
    parameter int COORD_BITS              = COORD_BITS_DEF,
    parameter int DISPARITY_FRACTION_BITS = DISP_FRAC_BITS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] column,
    input  wire logic [COORD_BITS-1:0] row,
    input  wire logic [DISP_W-1:0]     disparity,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       done,
    output logic signed [OUT_W-1:0]    world_x,
    output logic signed [OUT_W-1:0]    world_y,
    output logic signed [OUT_W-1:0]    world_z
);

    localparam int DW = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1;
    localparam int IW = 2 * DW + DISP_W;
    localparam logic [ROT_W-1:0] ROT_ONE = ROT_W'(1 << ROT_FRAC);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEPTH_SCALE: cfg_next.depth_scale = cfg_data[31:0];
                REG_FOCAL_X:     cfg_next.focal_x     = cfg_data[15:0];
                REG_FOCAL_Y:     cfg_next.focal_y     = cfg_data[15:0];
                REG_PRINCIPAL:
                begin
                    cfg_next.cx = cfg_data[15:0];
                    cfg_next.cy = cfg_data[31:16];
                end
                REG_ROT_ROW0:    cfg_next.rot[0]      = cfg_data[47:0];
                REG_ROT_ROW1:    cfg_next.rot[1]      = cfg_data[47:0];
                REG_ROT_ROW2:    cfg_next.rot[2]      = cfg_data[47:0];
                REG_TRANSLATION: cfg_next.trans       = cfg_data[62:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= '0;
            cfg_reg.focal_x     <= 16'd16;
            cfg_reg.focal_y     <= 16'd16;
            cfg_reg.cx          <= '0;
            cfg_reg.cy          <= '0;
            cfg_reg.rot[0]      <= {{(2*ROT_W){1'b0}}, ROT_ONE};
            cfg_reg.rot[1]      <= {{ROT_W{1'b0}}, ROT_ONE, {ROT_W{1'b0}}};
            cfg_reg.rot[2]      <= {ROT_ONE, {(2*ROT_W){1'b0}}};
            cfg_reg.trans       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic          take;
    logic          push, q_empty, q_afull;
    logic [IW-1:0] push_data, pop_data;

    assign busy = q_afull;
    assign take = start && !busy;

    dtwp_front #(
        .COORD_BITS(COORD_BITS),
        .DISPARITY_FRACTION_BITS(DISPARITY_FRACTION_BITS),
        .DW(DW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .column(column), .row(row), .disparity(disparity),
        .cfg(cfg_reg), .push(push), .push_data(push_data)
    );

    dtwp_queue #(.WIDTH(IW), .DEPTH(Q_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data),
        .pop(!q_empty), .pop_data(pop_data),
        .empty(q_empty), .almost_full(q_afull)
    );

    dtwp_back #(
        .COORD_BITS(COORD_BITS),
        .DISPARITY_FRACTION_BITS(DISPARITY_FRACTION_BITS),
        .DW(DW)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(!q_empty), .in_data(pop_data), .cfg(cfg_reg),
        .done(done), .world_x(world_x), .world_y(world_y), .world_z(world_z)
    );

endmodule

`default_nettype wire

// File: verif/dtwp_checker.sv
`default_nettype none

module dtwp_checker
    import dtwp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [11:0]           column,
    input  wire logic [11:0]           row,
    input  wire logic [DISP_W-1:0]     disparity,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  done,
    input  wire logic signed [31:0]    world_x,
    input  wire logic signed [31:0]    world_y,
    input  wire logic signed [31:0]    world_z,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    logic [31:0] depth_scale;
    logic [15:0] focal_x, focal_y;
    logic [31:0] principal;
    logic [47:0] rot_row [3];
    logic [62:0] translation;
    point_t      expected_points [$];

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint rotate_row(logic [47:0] rv, longint q[3], longint r[3],
                                          logic [20:0] t);
        longint hi, lo, e;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++)
        begin
            e = longint'($signed(rv[k*16 +: 16]));
            hi += e * q[k];
            lo += e * r[k];
        end
        return hi + (lo >>> ROT_FRAC) + longint'($signed(t));
    endfunction

    function automatic point_t world_point(logic [11:0] col, logic [11:0] rw,
                                           logic [11:0] disp);
        longint z, fx, fy, cam[3], q[3], r[3];
        point_t p;
        z = longint'({depth_scale, 4'b0}) / longint'(disp);
        fx = (focal_x == 0) ? 1 : longint'(focal_x);
        fy = (focal_y == 0) ? 1 : longint'(focal_y);
        cam[0] = ((longint'({col, 4'b0}) - longint'(principal[15:0])) * z) / fx;
        cam[1] = ((longint'({rw, 4'b0}) - longint'(principal[31:16])) * z) / fy;
        cam[2] = z;
        for (int k = 0; k < 3; k++)
        begin
            q[k] = cam[k] >>> ROT_FRAC;
            r[k] = cam[k] - (q[k] <<< ROT_FRAC);
        end
        p.x = clamp32(rotate_row(rot_row[0], q, r, translation[20:0]));
        p.y = clamp32(rotate_row(rot_row[1], q, r, translation[41:21]));
        p.z = clamp32(rotate_row(rot_row[2], q, r, translation[62:42]));
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t exp_p;
        int     nerr;
        if (!rst_n)
        begin
            depth_scale = '0;
            focal_x = 16;
            focal_y = 16;
            principal = '0;
            rot_row[0] = 48'h0000_0000_4000;
            rot_row[1] = 48'h0000_4000_0000;
            rot_row[2] = 48'h4000_0000_0000;
            translation = '0;
            expected_points.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            nerr = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEPTH_SCALE: depth_scale = cfg_data[31:0];
                    REG_FOCAL_X:     focal_x = cfg_data[15:0];
                    REG_FOCAL_Y:     focal_y = cfg_data[15:0];
                    REG_PRINCIPAL:   principal = cfg_data[31:0];
                    REG_ROT_ROW0:    rot_row[0] = cfg_data[47:0];
                    REG_ROT_ROW1:    rot_row[1] = cfg_data[47:0];
                    REG_ROT_ROW2:    rot_row[2] = cfg_data[47:0];
                    REG_TRANSLATION: translation = cfg_data[62:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d z=%0d", world_x, world_y, world_z);
                    nerr++;
                end
                else
                begin
                    exp_p = expected_points.pop_front();
                    if (world_x !== exp_p.x)
                    begin
                        $error("world_x expected %0d actual %0d", exp_p.x, world_x);
                        nerr++;
                    end
                    if (world_y !== exp_p.y)
                    begin
                        $error("world_y expected %0d actual %0d", exp_p.y, world_y);
                        nerr++;
                    end
                    if (world_z !== exp_p.z)
                    begin
                        $error("world_z expected %0d actual %0d", exp_p.z, world_z);
                        nerr++;
                    end
                end
            end
            // pixels at or below the minimum disparity produce nothing
            if (start && !busy && disparity > (MIN_DISP_PX << DISP_FRAC_BITS_DEF))
                expected_points = {expected_points, world_point(column, row, disparity)};
            errors <= errors + nerr;
            pending <= expected_points.size();
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
    import dtwp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [11:0]           column, row;
    logic [DISP_W-1:0]     disparity;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic signed [31:0]    world_x, world_y, world_z;
    int                    errors, pending, idle_cycles;
    int                    gap_mode;

    disparity_to_world_point dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .column(column), .row(row), .disparity(disparity),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .world_x(world_x), .world_y(world_y), .world_z(world_z)
    );

    dtwp_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .column(column), .row(row), .disparity(disparity),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (gap_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [11:0] d);
        int gap;
        start <= 1'b1;
        column <= c;
        row <= r;
        disparity <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] realistic_value(int idx);
        logic [15:0] e [3];
        for (int k = 0; k < 3; k++)
            e[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
        case (idx)
            REG_DEPTH_SCALE: return $urandom_range(1000, 4000000);
            REG_FOCAL_X, REG_FOCAL_Y: return $urandom_range(16 * 200, 16 * 1500);
            REG_PRINCIPAL:
                return {32'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
            REG_ROT_ROW0, REG_ROT_ROW1, REG_ROT_ROW2: return {16'b0, e[2], e[1], e[0]};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // kind: 0 zeros, 1 all ones, 2 sign-bit pattern, 3 random, 4 realistic, negative picks one per register at random
    task automatic configure(int kind);
        logic [63:0] v;
        int          k;
        for (int idx = REG_DEPTH_SCALE; idx <= REG_TRANSLATION; idx++)
        begin
            k = (kind < 0) ? $urandom_range(0, 4) : kind;
            case (k)
                0: v = '0;
                1: v = '1;
                2: v = 64'h0000_8000_8000_7FFF;
                3: v = {$urandom, $urandom};
                default: v = realistic_value(idx);
            endcase
            write_reg(CFG_IDX_W'(idx), v);
        end
        // out-of-range index must be ignored
        write_reg(CFG_IDX_W'(REG_TRANSLATION) + CFG_IDX_W'($urandom_range(1, 8)),
                  {$urandom, $urandom});
    endtask

    task automatic directed_pixels();
        send_pixel(12'd0, 12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095, 12'd80);
        send_pixel(12'd0, 12'd4095, 12'd81);
        send_pixel(12'd4095, 12'd0, 12'd81);
        send_pixel(12'd4095, 12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0, 12'd4095);
        send_pixel(12'd2048, 12'd1024, 12'd96);
        send_pixel(12'd1, 12'd2, 12'd79);
        send_pixel(12'hAAA, 12'h555, 12'hAAA);
        send_pixel(12'h555, 12'hAAA, 12'h555);
    endtask

    task automatic random_pixels(int count);
        logic [11:0] d;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                d = $urandom_range(81, 4095);
            else
                d = $urandom_range(0, 80);
            send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), d);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        column = '0;
        row = '0;
        disparity = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        gap_mode = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration
        directed_pixels();
        wait_idle();
        configure(4);
        directed_pixels();
        wait_idle();
        configure(1);
        directed_pixels();
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0, 3: configure(4);
                1:    configure(1);
                2:    configure(0);
                4:    configure(2);
                default: configure(-1);
            endcase
            gap_mode = (phase % 3 == 0) ? 0 : 1;
            random_pixels(150);
            wait_idle();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
